### rtl/lcgs_pkg.sv
package lcgs_pkg;

  // Shuffle table geometry and warm-up length of a reseed.
  localparam int unsigned TABLE_SIZE   = 32;
  localparam int unsigned WARMUP_EXTRA = 8;
  localparam int unsigned WARMUP_STEPS = TABLE_SIZE + WARMUP_EXTRA;
  localparam int unsigned TBL_AW       = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W        = $clog2(WARMUP_STEPS);

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MULT_W = 16;
  localparam int unsigned FOLD_W = 8;
  localparam int unsigned PROD_W = VAL_W + MULT_W;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [MULT_W-1:0] mult_t;
  typedef logic [FOLD_W-1:0] fold_t;
  typedef logic [TBL_AW-1:0] tbl_addr_t;

  // Request function codes.
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  // Both moduli sit just below 2^31, so 2^31 folds back as a small constant.
  localparam val_t  MOD1        = 31'd2147483563;
  localparam val_t  MOD2        = 31'd2147483399;
  localparam mult_t MULT1       = 16'd40014;
  localparam mult_t MULT2       = 16'd40692;
  localparam fold_t FOLD1       = 8'd85;
  localparam fold_t FOLD2       = 8'd249;
  localparam val_t  OUT_MAX     = 31'd2147483562;
  localparam val_t  SECOND_INIT = 31'd123456789;

  // Slot selection divides the last output by SLOT_DIV. The reciprocal
  // estimate is never high and at most one below the true quotient.
  localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483562 / TABLE_SIZE;
  localparam longint unsigned SLOT_MUL = (64'd1 << VAL_W) / SLOT_DIV;
  localparam int unsigned     SMUL_W   = $clog2(SLOT_MUL + 1);
  localparam int unsigned     SPROD_W  = VAL_W + SMUL_W;
  localparam int unsigned     THR_W    = VAL_W + 1;

  typedef struct packed {
    logic      we;
    tbl_addr_t addr;
    val_t      data;
  } tbl_wr_t;

  typedef struct packed {
    logic      re;
    tbl_addr_t addr;
  } tbl_rd_t;

endpackage

### rtl/lcgs_if.sv
interface lcgs_req_if;
  import lcgs_pkg::*;

  logic valid;
  logic ready;
  logic func;
  val_t seed;

  modport source (output valid, output func, output seed, input ready);
  modport sink (input valid, input func, input seed, output ready);
endinterface

interface lcgs_rsp_if;
  import lcgs_pkg::*;

  logic valid;
  logic ready;
  val_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/lcgs_mcg_step.sv
module lcgs_mcg_step (
  input  logic           clk,
  input  logic           load,
  input  lcgs_pkg::val_t  z,
  input  lcgs_pkg::mult_t mult,
  input  lcgs_pkg::val_t  modulus,
  input  lcgs_pkg::fold_t fold,
  output lcgs_pkg::val_t  result
);
  import lcgs_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [MULT_W-1:0] hi;
  logic [VAL_W-1:0]  lo;
  logic [VAL_W:0]    sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(z) * PROD_W'(mult);
    end
  end

  // The high part is worth hi * 2^31, which is hi * fold modulo the modulus.
  // The folded sum stays below twice the modulus, so one subtraction reduces it.
  assign hi  = prod_r[PROD_W-1:VAL_W];
  assign lo  = prod_r[VAL_W-1:0];
  assign sum = (VAL_W+1)'(hi * fold) + {1'b0, lo};

  always_comb begin
    if (sum >= {1'b0, modulus}) begin
      result = VAL_W'(sum - {1'b0, modulus});
    end else begin
      result = sum[VAL_W-1:0];
    end
  end

endmodule

### rtl/lcgs_table.sv
module lcgs_table (
  input  logic              clk,
  input  logic              rst_n,
  input  lcgs_pkg::tbl_wr_t wr,
  input  lcgs_pkg::tbl_rd_t rd,
  output lcgs_pkg::val_t    rd_data
);
  import lcgs_pkg::*;

  val_t                  mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  val_t                  rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // An entry that has never been written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.re) begin
        rd_vld_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/combined_lcg_shuffle_rng.sv
// Combined two-generator congruential random source with a shuffle table.
// Requests arrive on in_chan (func, seed) with a valid/ready handshake and
// results leave on out_chan (value), one result for every request.
// func 0 draws the next value; func 1 reseeds from seed, zero taken as one,
// then draws. The uniform deviate is value divided by 2147483563.
// In a draw the generator and slot multipliers are loaded at acceptance, the
// next cycle reduces them and reads the shuffle table, and the cycle after
// writes the table back and registers the result. A reseed runs 40 warm-up
// steps of generator one, the multiply and fold of one step feeding the
// next, then the draw.
// One request is worked on at a time; in_chan.ready is high while idle.
// The output register holds one result, so a request is accepted while a
// result still waits; if out_chan stays stalled, that request holds in its
// write-back cycle and touches nothing until the waiting result is taken.
// Synchronous reset restores generator one to 1, generator two to 123456789,
// the last output to 0 and every table entry to zero, and drops out_chan.valid.
module combined_lcg_shuffle_rng (
  input logic        clk,
  input logic        rst_n,
  lcgs_req_if.sink   in_chan,
  lcgs_rsp_if.source out_chan
);
  import lcgs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SMUL = 6'b000010,
    ST_SRED = 6'b000100,
    ST_DMUL = 6'b001000,
    ST_RED  = 6'b010000,
    ST_WB   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  val_t               gen1_r, gen1_nxt;
  val_t               gen2_r, gen2_nxt;
  val_t               last_out_r, last_out_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  tbl_addr_t          slot_r, slot_nxt;
  logic [SPROD_W-1:0] slot_prod_r;
  logic               out_valid_r, out_valid_nxt;
  val_t               out_value_r, out_value_nxt;

  logic      in_acc;
  logic      step_load;
  logic      wb_go;
  val_t      seed_fix;
  val_t      step1_res;
  val_t      step2_res;
  val_t      tbl_data;
  tbl_wr_t   tbl_wr;
  tbl_rd_t   tbl_rd;

  logic [SMUL_W-1:0] q_est;
  logic [SMUL_W:0]   q_inc;
  logic [SMUL_W:0]   q_cor;
  logic [THR_W-1:0]  thr;
  tbl_addr_t         slot_calc;

  logic signed [VAL_W+1:0] diff;
  logic signed [VAL_W+1:0] diff_adj;
  val_t                    draw_val;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;

  assign seed_fix  = (in_chan.seed == '0) ? VAL_W'(1) : in_chan.seed;
  assign step_load = (in_acc && (in_chan.func == FUNC_DRAW)) || (state_r == ST_SMUL) ||
                     (state_r == ST_DMUL);
  assign wb_go     = (state_r == ST_WB) && (!out_valid_r || out_chan.ready);

  lcgs_mcg_step u_step1 (
    .clk     (clk),
    .load    (step_load),
    .z       (gen1_r),
    .mult    (MULT1),
    .modulus (MOD1),
    .fold    (FOLD1),
    .result  (step1_res)
  );

  lcgs_mcg_step u_step2 (
    .clk     (clk),
    .load    (step_load),
    .z       (gen2_r),
    .mult    (MULT2),
    .modulus (MOD2),
    .fold    (FOLD2),
    .result  (step2_res)
  );

  lcgs_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_data)
  );

  // Slot index: the reciprocal estimate is corrected upwards by one compare.
  assign q_est = slot_prod_r[SPROD_W-1:VAL_W];
  assign q_inc = {1'b0, q_est} + (SMUL_W+1)'(1);
  assign thr   = THR_W'(q_inc) * THR_W'(SLOT_DIV);
  assign q_cor = ({1'b0, last_out_r} >= thr) ? q_inc : {1'b0, q_est};

  always_comb begin
    if (q_cor >= (SMUL_W+1)'(TABLE_SIZE)) begin
      slot_calc = TBL_AW'(TABLE_SIZE - 1);
    end else begin
      slot_calc = q_cor[TBL_AW-1:0];
    end
  end

  assign tbl_rd.re   = (state_r == ST_RED);
  assign tbl_rd.addr = slot_calc;

  // Warm-up fills the table from the top slot down; a draw puts the new
  // generator-one value back into the slot it has just read.
  always_comb begin
    tbl_wr.we   = 1'b0;
    tbl_wr.addr = slot_r;
    tbl_wr.data = gen1_r;
    if ((state_r == ST_SRED) && (cnt_r < CNT_W'(TABLE_SIZE))) begin
      tbl_wr.we   = 1'b1;
      tbl_wr.addr = cnt_r[TBL_AW-1:0];
      tbl_wr.data = step1_res;
    end else if (wb_go) begin
      tbl_wr.we = 1'b1;
    end
  end

  assign diff     = $signed({2'b00, tbl_data}) - $signed({2'b00, gen2_r});
  assign diff_adj = (diff < 1) ? diff + $signed({2'b00, OUT_MAX}) : diff;
  assign draw_val = diff_adj[VAL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    gen1_nxt      = gen1_r;
    gen2_nxt      = gen2_r;
    last_out_nxt  = last_out_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_value_nxt = out_value_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == FUNC_RESEED) begin
            gen1_nxt  = seed_fix;
            gen2_nxt  = seed_fix;
            cnt_nxt   = CNT_W'(WARMUP_STEPS - 1);
            state_nxt = ST_SMUL;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end
      ST_SMUL: begin
        state_nxt = ST_SRED;
      end
      ST_SRED: begin
        gen1_nxt = step1_res;
        if (cnt_r == '0) begin
          last_out_nxt = step1_res;
          state_nxt    = ST_DMUL;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_SMUL;
        end
      end
      ST_DMUL: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        gen1_nxt  = step1_res;
        gen2_nxt  = step2_res;
        slot_nxt  = slot_calc;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (wb_go) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = draw_val;
          last_out_nxt  = draw_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen1_r      <= VAL_W'(1);
      gen2_r      <= SECOND_INIT;
      last_out_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen1_r      <= gen1_nxt;
      gen2_r      <= gen2_nxt;
      last_out_r  <= last_out_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    out_value_r <= out_value_nxt;
    if (step_load) begin
      slot_prod_r <= SPROD_W'(last_out_r) * SPROD_W'(SLOT_MUL);
    end
  end

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r >= VAL_W'(1) && out_value_r <= OUT_MAX))
    else $error("result outside 1 to OUT_MAX");

  a_gen_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RED) |=> (gen1_r < MOD1 && gen2_r < MOD2))
    else $error("generator state not reduced after a draw step");

  a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_valid_r && !out_chan.ready) |-> !tbl_wr.we)
    else $error("table written while the result register is still full");

  a_warm_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRED && cnt_r == '0) |=>
      (state_r == ST_DMUL && last_out_r == gen1_r))
    else $error("warm-up did not hand slot zero over to the draw");

endmodule
